// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define UU_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define UU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UU_ASSERT(label, clk, rstn, prop, msg)
`define UU_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== rtl/uutg_pkg.sv =====
// Shared types, codes and constants of the task share generator.
package uutg_pkg;

    localparam int FRAC_BITS = 24;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_ABORT = 2'd1;
    localparam logic [1:0] STAT_SAT   = 2'd2;

    localparam logic [1:0] REG_TOTAL = 2'd0;
    localparam logic [1:0] REG_COUNT = 2'd1;

    typedef struct packed {
        logic        start;
        logic [55:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [55:0] quotient;
        logic [31:0] remainder;
    } div_rsp_t;

    // 2^(-2^-j) in Q0.32, by repeated integer square roots (elaboration only)
    function automatic logic [31:0] exp_tab_entry(input int j);
        logic [63:0] v;
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] b;
        v = 64'h8000_0000;
        for (int i = 1; i <= j; i++) begin
            x   = v << 32;
            res = 64'd0;
            b   = 64'd1 << 62;
            while (b > x) b = b >> 2;
            while (b != 64'd0) begin
                if (x >= res + b) begin
                    x   = x - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            v = (res > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : res;
        end
        return v[31:0];
    endfunction

endpackage

// ===== rtl/uunifast_task_share_generator.sv =====
// UUniFast task share generator: sequencer around a shared multiplier and divider.
//
// Usage: write total_utilization (index 0, Q8.24) and task_count (index 1) over the
// cfg channel. cfg_ready is high only while the block is idle, and either write
// restarts the task set. Feed one word per task on s_ (tdata: random_word, task_period,
// task_wcet, thread_count). s_tready is held low while a register write is offered.
// Each task gives one word on m_ (tdata: share, period_out, wcet_out, threads_out;
// tuser: status; tlast: final task of the set). After a task with no period and no WCET
// the rest of the set is swallowed without results, one cycle per word while no register
// write is offered, and the next set starts clean. The last task of a set takes the
// remaining share. Other tasks go straight to the scaling step for a random word of 0 or
// all ones; any other task is normalised, squared once per fraction bit, divided in the
// shared divider, raised through the root table bit by bit, given the linear term and
// scaled. Then a missing period is derived in the divider, or the WCET in the multiplier.
// The block takes no new word until the current one is through: the shared divider
// and the one multiplier serve one word at a time, and s_tready is low meanwhile.
// A finished word sits in the output register, so s_tready returns while it waits; a
// stalled receiver holds the next result in S_OUT, and s_tready then stays low.
// Reset: total_utilization 1.0, task_count 1, set restarted, no output pending.
`include "assert_macros.svh"
module uunifast_task_share_generator import uutg_pkg::*; #(
    parameter int MAX_TASKS       = 64,
    parameter int ROOT_TABLE_BITS = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // random_word, task_period, task_wcet, thread_count
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // share, period_out, wcet_out, threads_out
    output logic [1:0]   m_tuser,   // status
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    localparam int JW = $clog2(ROOT_TABLE_BITS + 1);
    localparam int DW = FRAC_BITS - ROOT_TABLE_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_NORM, S_SQ_MUL, S_SQ_UPD, S_LG_DIV, S_LG_WAIT, S_EXP_MUL, S_EXP_UPD,
        S_EXP_NEXT, S_DL_MUL, S_DL_UPD, S_DF_MUL, S_DF_UPD, S_SHIFT, S_R_MUL, S_R_UPD,
        S_FIN, S_PD_DIV, S_PD_WAIT, S_WC_MUL, S_WC_UPD, S_OUT
    } state_t;

    state_t       state_reg;
    // set state
    logic [31:0]  total_reg;
    logic [6:0]   tcount_reg;
    logic [31:0]  rem_reg;
    logic [6:0]   idx_reg;
    logic         aborted_reg;
    // item in work
    logic [31:0]  per_reg, wc_reg, share_reg, pout_reg, wout_reg, m_reg, fac_reg;
    logic [7:0]   th_reg, tout_reg;
    logic [1:0]   st_reg;
    logic         last_reg;
    logic [6:0]   k_reg;
    logic [4:0]   s_reg, step_reg, n_reg;
    logic [23:0]  frac_reg, f_reg;
    logic [JW-1:0] j_reg;
    logic [32:0]  p_reg;
    // output register
    logic         m_tvalid_reg, m_tlast_reg;
    logic [103:0] m_tdata_reg;
    logic [1:0]   m_tuser_reg;

    logic [31:0]  tab [ROOT_TABLE_BITS+1];
    logic [6:0]   cnt_eff, idx_e, k_next;
    logic         wrap, aborted_e, last_next;
    logic [31:0]  rem_e;
    logic [32:0]  mul_a;
    logic [31:0]  mul_b;
    logic [64:0]  prod_reg;
    div_req_t     div_req;
    div_rsp_t     div_rsp;
    logic [5:0]   s_plus;
    logic [29:0]  lq;
    logic [32:0]  sq_t;
    logic         fbit;
    logic [64:0]  wsum;
    logic         r_nz;
    logic         accept;
    logic         out_load;

    for (genvar g = 0; g <= ROOT_TABLE_BITS; g++) begin : g_tab
        assign tab[g] = exp_tab_entry(g);
    end

    uutg_mul u_mul (.aclk(aclk), .a(mul_a), .b(mul_b), .prod_reg(prod_reg));
    uutg_div u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp));

    always_comb begin
        if (tcount_reg == 7'd0)              cnt_eff = 7'd1;
        else if (int'(tcount_reg) > MAX_TASKS) cnt_eff = 7'(MAX_TASKS);
        else                                 cnt_eff = tcount_reg;
        wrap      = idx_reg >= cnt_eff;
        idx_e     = wrap ? 7'd0 : idx_reg;
        aborted_e = wrap ? 1'b0 : aborted_reg;
        rem_e     = wrap ? total_reg : rem_reg;
        k_next    = cnt_eff - idx_e;
        last_next = k_next == 7'd1;
        accept    = s_tvalid && s_tready;
        out_load  = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

        s_plus = 6'(s_reg) + 6'd1;
        lq     = {s_plus, 24'd0} - {6'd0, frac_reg};
        sq_t   = prod_reg[63:31];
        fbit   = f_reg[5'(FRAC_BITS) - 5'(j_reg)];
        wsum   = {1'b0, prod_reg[63:0]} + 65'h00_00FF_FFFF;
        r_nz   = div_rsp.remainder != 32'd0;

        // operand select for the shared multiplier
        case (state_reg)
            S_SQ_MUL:  begin mul_a = {1'b0, m_reg};        mul_b = m_reg;    end
            S_EXP_MUL: begin mul_a = p_reg;                mul_b = tab[j_reg]; end
            S_DL_MUL:  begin mul_a = 33'(f_reg[DW-1:0]);   mul_b = LN2_Q32;  end
            S_DF_MUL:  begin mul_a = p_reg;                mul_b = fac_reg;  end
            S_R_MUL:   begin mul_a = p_reg;                mul_b = rem_reg;  end
            S_WC_MUL:  begin mul_a = {1'b0, per_reg};      mul_b = share_reg; end
            default:   begin mul_a = '0;                   mul_b = '0;       end
        endcase

        div_req.start    = (state_reg == S_LG_DIV) || (state_reg == S_PD_DIV);
        div_req.dividend = (state_reg == S_PD_DIV) ? {wc_reg, 24'd0} : 56'(lq);
        div_req.divisor  = (state_reg == S_PD_DIV) ? share_reg : 32'(k_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            total_reg    <= 32'h0100_0000;
            tcount_reg   <= 7'd1;
            rem_reg      <= 32'h0100_0000;
            idx_reg      <= '0;
            aborted_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready) m_tvalid_reg <= 1'b0;

            // register writes restart the set
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_TOTAL: begin
                        total_reg   <= cfg_data;
                        rem_reg     <= cfg_data;
                        idx_reg     <= '0;
                        aborted_reg <= 1'b0;
                    end
                    REG_COUNT: begin
                        tcount_reg  <= cfg_data[6:0];
                        rem_reg     <= total_reg;
                        idx_reg     <= '0;
                        aborted_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if (aborted_e) begin
                            // swallow the word, advance through the set
                            idx_reg <= last_next ? 7'd0 : idx_e + 7'd1;
                            if (last_next) begin
                                rem_reg     <= total_reg;
                                aborted_reg <= 1'b0;
                            end
                        end else begin
                            idx_reg     <= idx_e;
                            rem_reg     <= last_next ? 32'd0 : rem_e;
                            aborted_reg <= 1'b0;
                            per_reg  <= s_tdata[63:32];
                            wc_reg   <= s_tdata[95:64];
                            th_reg   <= s_tdata[103:96];
                            pout_reg <= s_tdata[63:32];
                            wout_reg <= s_tdata[95:64];
                            tout_reg <= s_tdata[103:96];
                            st_reg   <= STAT_OK;
                            k_reg    <= k_next;
                            last_reg <= last_next;
                            m_reg    <= s_tdata[31:0];
                            s_reg    <= '0;
                            if (last_next) begin
                                share_reg <= rem_e;
                                state_reg <= S_FIN;
                            end else if (s_tdata[31:0] == 32'd0) begin
                                p_reg     <= '0;
                                state_reg <= S_R_MUL;
                            end else if (s_tdata[31:0] == 32'hFFFF_FFFF) begin
                                p_reg     <= 33'h1_0000_0000;
                                state_reg <= S_R_MUL;
                            end else begin
                                state_reg <= S_NORM;
                            end
                        end
                    end
                end
                S_NORM: begin
                    // shift the sample up until its top bit is set
                    if (m_reg[31]) begin
                        step_reg  <= '0;
                        frac_reg  <= '0;
                        state_reg <= S_SQ_MUL;
                    end else begin
                        m_reg <= {m_reg[30:0], 1'b0};
                        s_reg <= s_reg + 5'd1;
                    end
                end
                S_SQ_MUL: state_reg <= S_SQ_UPD;
                S_SQ_UPD: begin
                    m_reg    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
                    frac_reg <= {frac_reg[22:0], sq_t[32]};
                    if (step_reg == 5'(FRAC_BITS - 1)) begin
                        state_reg <= S_LG_DIV;
                    end else begin
                        step_reg  <= step_reg + 5'd1;
                        state_reg <= S_SQ_MUL;
                    end
                end
                S_LG_DIV: state_reg <= S_LG_WAIT;
                S_LG_WAIT: begin
                    if (div_rsp.done) begin
                        if (div_rsp.quotient[29]) begin
                            p_reg     <= '0;
                            state_reg <= S_R_MUL;
                        end else begin
                            n_reg     <= div_rsp.quotient[28:24];
                            f_reg     <= div_rsp.quotient[23:0];
                            p_reg     <= 33'h1_0000_0000;
                            j_reg     <= JW'(1);
                            state_reg <= S_EXP_MUL;
                        end
                    end
                end
                S_EXP_MUL: state_reg <= fbit ? S_EXP_UPD : S_EXP_NEXT;
                S_EXP_UPD: begin
                    p_reg     <= 33'((prod_reg + 65'h8000_0000) >> 32);
                    state_reg <= S_EXP_NEXT;
                end
                S_EXP_NEXT: begin
                    if (j_reg == JW'(ROOT_TABLE_BITS)) begin
                        state_reg <= (f_reg[DW-1:0] != '0) ? S_DL_MUL : S_SHIFT;
                    end else begin
                        j_reg     <= j_reg + JW'(1);
                        state_reg <= S_EXP_MUL;
                    end
                end
                S_DL_MUL: state_reg <= S_DL_UPD;
                S_DL_UPD: begin
                    fac_reg   <= 32'(33'h1_0000_0000 - 33'(prod_reg[64:24]));
                    state_reg <= S_DF_MUL;
                end
                S_DF_MUL: state_reg <= S_DF_UPD;
                S_DF_UPD: begin
                    p_reg     <= prod_reg[64:32];
                    state_reg <= S_SHIFT;
                end
                S_SHIFT: begin
                    p_reg     <= p_reg >> n_reg;
                    state_reg <= S_R_MUL;
                end
                S_R_MUL: state_reg <= S_R_UPD;
                S_R_UPD: begin
                    share_reg <= rem_reg - prod_reg[63:32];
                    rem_reg   <= prod_reg[63:32];
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (per_reg == 32'd0) begin
                        if (wc_reg == 32'd0) begin
                            st_reg      <= STAT_ABORT;
                            aborted_reg <= 1'b1;
                            state_reg   <= S_OUT;
                        end else if (share_reg == 32'd0) begin
                            pout_reg  <= 32'hFFFF_FFFF;
                            st_reg    <= STAT_SAT;
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_PD_DIV;
                        end
                    end else begin
                        if (th_reg == 8'd0) tout_reg <= 8'd1;
                        state_reg <= S_WC_MUL;
                    end
                end
                S_PD_DIV: state_reg <= S_PD_WAIT;
                S_PD_WAIT: begin
                    if (div_rsp.done) begin
                        // ceiling of the quotient, saturate past 32 bits
                        if ((div_rsp.quotient[55:32] != '0) ||
                            ((&div_rsp.quotient[31:0]) && r_nz)) begin
                            pout_reg <= 32'hFFFF_FFFF;
                            st_reg   <= STAT_SAT;
                        end else begin
                            pout_reg <= div_rsp.quotient[31:0] + 32'(r_nz);
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_WC_MUL: state_reg <= S_WC_UPD;
                S_WC_UPD: begin
                    if (wsum[64:56] != '0) begin
                        wout_reg <= 32'hFFFF_FFFF;
                        st_reg   <= STAT_SAT;
                    end else begin
                        wout_reg <= wsum[55:24];
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (out_load) begin
                        m_tdata_reg  <= {tout_reg, wout_reg, pout_reg, share_reg};
                        m_tuser_reg  <= st_reg;
                        m_tlast_reg  <= last_reg;
                        if (last_reg) begin
                            idx_reg     <= '0;
                            rem_reg     <= total_reg;
                            aborted_reg <= 1'b0;
                        end else begin
                            idx_reg <= idx_reg + 7'd1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = state_reg == S_IDLE;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tlast   = m_tlast_reg;

    `UU_ASSERT(a_busy_after_take, aclk, aresetn, s_tvalid && s_tready && !aborted_e |=> !s_tready, "word taken but block still ready")
    `UU_ASSERT(a_index_in_set, aclk, aresetn, state_reg != S_IDLE |-> idx_reg < cnt_eff, "task index beyond set")
    `UU_ASSERT(a_div_done_expected, aclk, aresetn, div_rsp.done |-> (state_reg == S_LG_WAIT || state_reg == S_PD_WAIT), "divider finished outside a wait state")
endmodule

// ===== rtl/uutg_mul.sv =====
// Shared 33x32 multiplier with registered product.
module uutg_mul (
    input  logic        aclk,
    input  logic [32:0] a,
    input  logic [31:0] b,
    output logic [64:0] prod_reg
);
    always_ff @(posedge aclk) begin
        prod_reg <= 65'(a) * 65'(b);
    end
endmodule

// ===== rtl/uutg_div.sv =====
// Restoring divider, one quotient bit per cycle, 56-bit dividend.
module uutg_div import uutg_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [55:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;
    logic [32:0] rem_shift;
    logic [32:0] rem_sub;
    logic        ge;
    logic [31:0] rem_next;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[55]};
        rem_sub   = rem_shift - {1'b0, dvs_reg};
        ge        = rem_shift >= {1'b0, dvs_reg};
        rem_next  = ge ? rem_sub[31:0] : rem_shift[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= req.dividend;
                rem_reg  <= '0;
                dvs_reg  <= req.divisor;
            end else if (busy_reg) begin
                quo_reg <= {quo_reg[54:0], ge};
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd55) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;
endmodule
